FILE: hw/rtl/fmv_pkg.sv
// Shared types, constants and the CRC-16 byte update for the framed message validator.
package fmv_pkg;

    localparam int unsigned HEADER_BYTES = 14;
    localparam int unsigned COUNT_W      = 17;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [15:0] CRC_POLY     = 16'h1189;

    localparam logic [7:0] TYPE_FIRST_RST  = 8'd2;
    localparam logic [7:0] TYPE_SECOND_RST = 8'd65;
    localparam logic [7:0] TYPE_THIRD_RST  = 8'd176;

    typedef enum logic [1:0] {
        REG_TYPE_FIRST  = 2'd0,
        REG_TYPE_SECOND = 2'd1,
        REG_TYPE_THIRD  = 2'd2
    } reg_index_t;

    typedef enum logic [2:0] {
        STATUS_OK       = 3'd0,
        STATUS_BAD_LEN  = 3'd1,
        STATUS_BAD_HDR  = 3'd2,
        STATUS_BAD_TYPE = 3'd3,
        STATUS_BAD_CRC  = 3'd4
    } status_t;

    // MSB-first CRC-16, one byte per call, no reflection
    function automatic logic [15:0] crc_feed(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] c;
        c = acc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

FILE: hw/rtl/framed_message_validator_top.sv
// Framed message validator: per-byte header, type, length and CRC-16 checks, one verdict per frame.
//
// Input channel: data_byte and last_byte with in_valid / in_stall. A transaction
// completes at a rising edge with in_valid high and in_stall low; one byte per cycle unless stalled.
// Output channel: status, type_index and payload_length with out_valid / out_stall.
// One output transaction per frame, for its last byte; other bytes produce nothing.
// The verdict is written into the output register at the edge that takes the last
// byte. Throughput: one byte per cycle while in_stall is low; the CRC update of one
// byte is combinational XOR logic feeding the running CRC register.
// A byte is taken in the same cycle that a held verdict leaves. in_stall is raised
// only while a verdict is held and the receiver stalls; all bytes wait then.
// Configuration: cfg_we with cfg_index 0..2 writes type code first/second/third;
// index 3 is ignored. Write only while no frame is in progress.
// Reset clears the frame state, the output register and restores the type codes
// to 2, 65 and 176.
module framed_message_validator_top
    import fmv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [1:0]  type_index,
    output logic [15:0] payload_length
);

    logic [7:0] type_first_reg, type_second_reg, type_third_reg;

    logic [COUNT_W-1:0] byte_count_reg, byte_count_next;
    logic [15:0]        crc_reg, crc_next;
    logic [7:0]         recent_reg [3];
    logic [7:0]         recent_next [3];
    logic               header_bad_reg, header_bad_next;
    logic [7:0]         type_byte_reg, type_byte_next;
    logic [15:0]        declared_reg, declared_next;

    logic               out_valid_reg, out_valid_next;
    status_t            status_reg, status_next;
    logic [1:0]         type_index_reg, type_index_next;
    logic [15:0]        length_reg, length_next;

    logic               in_accept;
    logic               out_accept;
    logic [15:0]        received;
    logic [COUNT_W-1:0] size_minus_13;

    assign in_stall   = out_valid_reg && out_stall;
    assign in_accept  = in_valid && !in_stall;
    assign out_accept = out_valid_reg && !out_stall;

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign type_index     = type_index_reg;
    assign payload_length = length_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            type_first_reg  <= TYPE_FIRST_RST;
            type_second_reg <= TYPE_SECOND_RST;
            type_third_reg  <= TYPE_THIRD_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TYPE_FIRST:  type_first_reg  <= cfg_data;
                REG_TYPE_SECOND: type_second_reg <= cfg_data;
                REG_TYPE_THIRD:  type_third_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    assign received      = {recent_reg[0], data_byte};
    assign size_minus_13 = byte_count_reg - COUNT_W'(12);

    always_comb
    begin
        byte_count_next = byte_count_reg;
        crc_next        = crc_reg;
        recent_next     = recent_reg;
        header_bad_next = header_bad_reg;
        type_byte_next  = type_byte_reg;
        declared_next   = declared_reg;
        out_valid_next  = out_valid_reg && !out_accept;
        status_next     = status_reg;
        type_index_next = type_index_reg;
        length_next     = length_reg;

        if (in_accept)
        begin
            if (byte_count_reg >= COUNT_W'(4))
                crc_next = crc_feed(crc_reg, recent_reg[2]);

            if (byte_count_reg <= COUNT_W'(4))
            begin
                if (data_byte != 8'h00)
                    header_bad_next = 1'b1;
            end
            else if (byte_count_reg == COUNT_W'(5) || byte_count_reg == COUNT_W'(13))
            begin
                if (data_byte != 8'hFF)
                    header_bad_next = 1'b1;
            end
            else if (byte_count_reg == COUNT_W'(6))
                type_byte_next = data_byte;
            else if (byte_count_reg == COUNT_W'(12))
                declared_next = received;

            if (last_byte)
            begin
                out_valid_next  = 1'b1;
                type_index_next = 2'd0;
                status_next     = STATUS_OK;
                length_next     = declared_next;
                if (byte_count_reg < COUNT_W'(HEADER_BYTES - 1))
                    status_next = STATUS_BAD_LEN;
                else if (header_bad_next)
                    status_next = STATUS_BAD_HDR;
                else if (type_byte_next != type_first_reg
                         && type_byte_next != type_second_reg
                         && type_byte_next != type_third_reg)
                    status_next = STATUS_BAD_TYPE;
                else if (size_minus_13 != {1'b0, declared_next})
                    status_next = STATUS_BAD_LEN;
                else if (crc_next != received)
                    status_next = STATUS_BAD_CRC;
                else if (type_byte_next == type_first_reg)
                    type_index_next = 2'd0;
                else if (type_byte_next == type_second_reg)
                    type_index_next = 2'd1;
                else
                    type_index_next = 2'd2;

                byte_count_next = '0;
                crc_next        = '0;
                recent_next[0]  = '0;
                recent_next[1]  = '0;
                recent_next[2]  = '0;
                header_bad_next = 1'b0;
                type_byte_next  = '0;
                declared_next   = '0;
            end
            else
            begin
                recent_next[2] = recent_reg[1];
                recent_next[1] = recent_reg[0];
                recent_next[0] = data_byte;
                if (byte_count_reg != COUNT_MAX)
                    byte_count_next = byte_count_reg + COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            crc_reg        <= '0;
            recent_reg[0]  <= '0;
            recent_reg[1]  <= '0;
            recent_reg[2]  <= '0;
            header_bad_reg <= 1'b0;
            type_byte_reg  <= '0;
            declared_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            byte_count_reg <= byte_count_next;
            crc_reg        <= crc_next;
            recent_reg     <= recent_next;
            header_bad_reg <= header_bad_next;
            type_byte_reg  <= type_byte_next;
            declared_reg   <= declared_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg     <= STATUS_OK;
            type_index_reg <= 2'd0;
            length_reg     <= '0;
        end
        else
        begin
            status_reg     <= status_next;
            type_index_reg <= type_index_next;
            length_reg     <= length_next;
        end
    end

    a_last_gives_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && last_byte |=> out_valid_reg)
        else $error("last byte taken without a verdict");

    a_verdict_needs_last: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg && !(in_accept && last_byte) |=> !out_valid_reg)
        else $error("verdict without a last byte");

    a_frame_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && last_byte |=> byte_count_reg == '0 && crc_reg == '0 && !header_bad_reg)
        else $error("frame state not cleared after last byte");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && !last_byte && byte_count_reg != COUNT_MAX
        |=> byte_count_reg == $past(byte_count_reg) + COUNT_W'(1))
        else $error("byte count did not advance");

    a_index_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg != STATUS_OK |-> type_index_reg == 2'd0)
        else $error("type index set on a failed frame");

endmodule

FILE: tb/fmv_checker.sv
// Frame verdict predictor and output checker for the framed message validator.
package fmv_tb_pkg;
    import fmv_pkg::*;

    localparam int unsigned LENGTH_BIAS = 13;

    function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
        logic fb;
        for (int k = 7; k >= 0; k--)
        begin
            fb  = crc[15] ^ b[k];
            crc = {crc[14:0], 1'b0};
            if (fb)
                crc = crc ^ CRC_POLY;
        end
        return crc;
    endfunction
endpackage

module fmv_checker
    import fmv_pkg::*;
    import fmv_tb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [2:0]  status,
    input  logic [1:0]  type_index,
    input  logic [15:0] payload_length,
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        status_t     status;
        logic [1:0]  type_index;
        logic [15:0] payload_length;
    } verdict_t;

    logic [7:0]         type_code [3];
    logic [COUNT_W-1:0] frame_bytes;
    logic [15:0]        crc_acc;
    logic [7:0]         hist [3];
    logic               hdr_bad;
    logic [7:0]         type_seen;
    logic [15:0]        len_field;
    verdict_t           verdict_q [$];
    int                 errors;

    function automatic void clear_frame();
        frame_bytes = '0;
        crc_acc     = '0;
        hist[0]     = '0;
        hist[1]     = '0;
        hist[2]     = '0;
        hdr_bad     = 1'b0;
        type_seen   = '0;
        len_field   = '0;
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        end
    endfunction

    // one byte through the frame state; a last byte queues the verdict
    task automatic take_byte(input logic [7:0] b, input logic last);
        int unsigned size;
        int          tindex;
        logic        known;
        verdict_t    v;
        if (frame_bytes >= 4)
            crc_acc = crc16_update(crc_acc, hist[2]);
        if (frame_bytes <= 4)
            hdr_bad = hdr_bad | (b != 8'h00);
        else if (frame_bytes == 5 || frame_bytes == 13)
            hdr_bad = hdr_bad | (b != 8'hFF);
        else if (frame_bytes == 6)
            type_seen = b;
        else if (frame_bytes == 12)
            len_field = {hist[0], b};

        if (last)
        begin
            size   = frame_bytes + 1;
            known  = 1'b0;
            tindex = 0;
            for (int i = 2; i >= 0; i--)
            begin
                if (type_seen == type_code[i])
                begin
                    known  = 1'b1;
                    tindex = i;
                end
            end
            v.payload_length = len_field;
            v.type_index     = 2'd0;
            if (size < HEADER_BYTES)
                v.status = STATUS_BAD_LEN;
            else if (hdr_bad)
                v.status = STATUS_BAD_HDR;
            else if (!known)
                v.status = STATUS_BAD_TYPE;
            else if (size - LENGTH_BIAS != len_field)
                v.status = STATUS_BAD_LEN;
            else if (crc_acc != {hist[0], b})
                v.status = STATUS_BAD_CRC;
            else
            begin
                v.status     = STATUS_OK;
                v.type_index = 2'(tindex);
            end
            verdict_q.push_back(v);
            clear_frame();
        end
        else
        begin
            hist[2] = hist[1];
            hist[1] = hist[0];
            hist[0] = b;
            if (frame_bytes != COUNT_MAX)
                frame_bytes++;
        end
    endtask

    always @(posedge clk)
    begin
        verdict_t want;
        if (!rst_n)
        begin
            type_code[REG_TYPE_FIRST]  = TYPE_FIRST_RST;
            type_code[REG_TYPE_SECOND] = TYPE_SECOND_RST;
            type_code[REG_TYPE_THIRD]  = TYPE_THIRD_RST;
            clear_frame();
            verdict_q.delete();
            errors = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                take_byte(data_byte, last_byte);
            if (out_valid && !out_stall)
            begin
                if (verdict_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected transaction status %0d type %0d length %0d",
                             $time, status, type_index, payload_length);
                end
                else
                begin
                    want = verdict_q.pop_front();
                    check_field("status", 16'(want.status), 16'(status));
                    check_field("type_index", 16'(want.type_index), 16'(type_index));
                    check_field("payload_length", want.payload_length, payload_length);
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_TYPE_FIRST, REG_TYPE_SECOND, REG_TYPE_THIRD:
                        type_code[cfg_index] = cfg_data;
                    default: ;
                endcase
            end
        end
        fail_count <= errors;
        pending    <= verdict_q.size();
    end

endmodule

FILE: tb/tb_top.sv
// Top of the framed message validator testbench: clock, reset, frame stimulus and verdict.
module tb_top
    import fmv_pkg::*;
    import fmv_tb_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_BYTES = 200;

    typedef enum {FLAW_NONE, FLAW_HEADER, FLAW_TYPE, FLAW_LENGTH, FLAW_CRC} flaw_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [7:0]  cfg_data = '0;
    logic        in_valid = 1'b0;
    logic [7:0]  data_byte = '0;
    logic        last_byte = 1'b0;
    logic        out_stall = 1'b0;
    logic        in_stall;
    logic        out_valid;
    logic [2:0]  status;
    logic [1:0]  type_index;
    logic [15:0] payload_length;
    int          fail_count;
    int          pending;

    logic [7:0]  codes [3] = '{TYPE_FIRST_RST, TYPE_SECOND_RST, TYPE_THIRD_RST};
    logic [7:0]  frame_q [$];
    int          gap_pct = 0;
    int          stall_pct = 0;
    int          phase_bytes = 0;
    bit          hold_pending = 1'b0;

    framed_message_validator_top DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .data_byte      (data_byte),
        .last_byte      (last_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .type_index     (type_index),
        .payload_length (payload_length)
    );

    fmv_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .data_byte      (data_byte),
        .last_byte      (last_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .type_index     (type_index),
        .payload_length (payload_length),
        .fail_count     (fail_count),
        .pending        (pending)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("tb_top failed");
        $finish;
    end

    // receiver: random stalls, plus one long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_pending)
            begin
                hold_pending = 1'b0;
                repeat (HOLD_CYCLES)
                begin
                    out_stall <= 1'b1;
                    @(posedge clk);
                end
            end
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    function automatic logic [7:0] unknown_type();
        logic [7:0] v;
        do
            v = 8'($urandom_range(255));
        while (v == codes[0] || v == codes[1] || v == codes[2]);
        return v;
    endfunction

    task automatic build_frame(input int n, input logic [7:0] type_b, input flaw_t flaw);
        logic [15:0] crc;
        logic [15:0] len;
        int          pos;
        frame_q.delete();
        repeat (n) frame_q.push_back(8'($urandom_range(255)));
        for (int i = 0; i < n && i < 5; i++)
            frame_q[i] = 8'h00;
        if (n > 5)
            frame_q[5] = 8'hFF;
        if (n > 6)
            frame_q[6] = (flaw == FLAW_TYPE) ? unknown_type() : type_b;
        if (n > 12)
        begin
            len = 16'(n - LENGTH_BIAS);
            if (flaw == FLAW_LENGTH)
                len = len ^ 16'($urandom_range(65535, 1));
            frame_q[11] = len[15:8];
            frame_q[12] = len[7:0];
        end
        if (n > 13)
            frame_q[13] = 8'hFF;
        if (flaw == FLAW_HEADER)
        begin
            pos = $urandom_range(6);
            if (pos == 6)
                pos = 13;
            if (pos < n)
                frame_q[pos] = frame_q[pos] ^ 8'($urandom_range(255, 1));
        end
        if (n >= 16)
        begin
            crc = '0;
            for (int i = 1; i <= n - 4; i++)
                crc = crc16_update(crc, frame_q[i]);
            frame_q[n-2] = crc[15:8];
            frame_q[n-1] = crc[7:0];
            if (flaw == FLAW_CRC)
            begin
                pos = n - 1 - $urandom_range(1);
                frame_q[pos] = frame_q[pos] ^ 8'($urandom_range(255, 1));
            end
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last);
        logic held;
        while ($urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        last_byte <= last;
        do
        begin
            @(negedge clk);
            held = in_stall;
            @(posedge clk);
        end
        while (held);
    endtask

    task automatic send_frame();
        foreach (frame_q[i])
            send_byte(frame_q[i], i == frame_q.size() - 1);
        phase_bytes += frame_q.size();
    endtask

    task automatic send_random_frame();
        int    r;
        int    n;
        flaw_t flaw;
        r = $urandom_range(99);
        if (r < 8)
        begin
            build_frame($urandom_range(40, 1), 8'h00, FLAW_NONE);
            foreach (frame_q[i])
                frame_q[i] = 8'($urandom_range(255));
        end
        else if (r < 14)
            build_frame($urandom_range(15, 1), codes[$urandom_range(2)], FLAW_NONE);
        else
        begin
            n = ($urandom_range(19) == 0) ? $urandom_range(400, 49) : $urandom_range(48, 16);
            case ($urandom_range(9))
                0: flaw = FLAW_HEADER;
                1: flaw = FLAW_TYPE;
                2: flaw = FLAW_LENGTH;
                3: flaw = FLAW_CRC;
                default: flaw = FLAW_NONE;
            endcase
            build_frame(n, codes[$urandom_range(2)], flaw);
        end
        send_frame();
    endtask

    // waits at falling edges so the checker's count has settled
    task automatic drain_verdicts();
        in_valid <= 1'b0;
        @(negedge clk);
        for (int k = 0; k < 20000 && pending != 0; k++)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    task automatic set_codes(input logic [7:0] a, input logic [7:0] b, input logic [7:0] c);
        write_reg(REG_TYPE_FIRST, a);
        write_reg(REG_TYPE_SECOND, b);
        write_reg(REG_TYPE_THIRD, c);
        write_reg(REG_UNUSED, 8'($urandom_range(255)));
        cfg_we <= 1'b0;
        codes[0] = a;
        codes[1] = b;
        codes[2] = c;
        @(posedge clk);
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed frames under the reset type codes
        build_frame(1, codes[0], FLAW_NONE);
        send_frame();
        build_frame(13, codes[0], FLAW_NONE);
        send_frame();
        build_frame(14, codes[1], FLAW_NONE);
        send_frame();
        build_frame(15, codes[2], FLAW_NONE);
        send_frame();
        build_frame(16, codes[0], FLAW_NONE);
        send_frame();
        build_frame(20, codes[1], FLAW_NONE);
        send_frame();
        build_frame(21, codes[2], FLAW_NONE);
        send_frame();
        build_frame(18, codes[0], FLAW_HEADER);
        send_frame();
        build_frame(18, codes[0], FLAW_TYPE);
        send_frame();
        build_frame(18, codes[1], FLAW_LENGTH);
        send_frame();
        build_frame(18, codes[2], FLAW_CRC);
        send_frame();
        // precedence: header over type, type over length, length over crc
        build_frame(18, codes[0], FLAW_HEADER);
        frame_q[6] = unknown_type();
        send_frame();
        build_frame(18, codes[0], FLAW_TYPE);
        frame_q[12] = frame_q[12] ^ 8'h01;
        send_frame();
        build_frame(18, codes[1], FLAW_LENGTH);
        frame_q[17] = frame_q[17] ^ 8'h80;
        send_frame();
        // largest length field
        build_frame(17, codes[2], FLAW_NONE);
        frame_q[11] = 8'hFF;
        frame_q[12] = 8'hFF;
        send_frame();

        for (int ph = 0; ph < 5; ph++)
        begin
            drain_verdicts();
            phase_bytes = 0;
            case (ph)
                0:
                begin
                    gap_pct   = 0;
                    stall_pct = 0;
                    hold_pending = 1'b1;
                    repeat (30)
                    begin
                        build_frame($urandom_range(3, 1), codes[0], FLAW_NONE);
                        send_frame();
                    end
                end
                1:
                begin
                    set_codes(8'h00, 8'hFF, 8'h80);
                    gap_pct   = 88;
                    stall_pct = 0;
                end
                2:
                begin
                    set_codes(8'h07, 8'h07, 8'h07);
                    gap_pct   = 0;
                    stall_pct = 88;
                end
                3:
                begin
                    set_codes(8'hFF, 8'h00, 8'hFF);
                    gap_pct   = 10;
                    stall_pct = 10;
                end
                default:
                begin
                    set_codes(8'($urandom_range(255)), 8'($urandom_range(255)),
                              8'($urandom_range(255)));
                    gap_pct   = 0;
                    stall_pct = 0;
                end
            endcase
            while (phase_bytes < PHASE_BYTES)
                send_random_frame();
        end

        drain_verdicts();
        repeat (8) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
